@@ hw/rtl/cu_pkg.sv @@
// Shared types and constants for the combination unranking block.
// Used by cu_ctrl, cu_dpath, cu_chk and the top level; depends on nothing.
`default_nettype none
package cu_pkg;

  localparam int MaxSet   = 64;
  localparam int NW       = 7;                  // set size / choose count width
  localparam int RankW    = 63;
  localparam int ValW     = 64;
  localparam int ElemW    = 6;
  localparam int TabRows  = MaxSet + 1;
  localparam int TabDepth = TabRows * TabRows;
  localparam int AddrW    = $clog2(TabDepth);
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegSetSize     = 1'd0;
  localparam logic [CfgIdxW-1:0] RegChooseCount = 1'd1;

  typedef enum logic [3:0] {
    ST_FILL_RD,
    ST_FILL_WR,
    ST_IDLE,
    ST_TOT_RD,
    ST_TOT_CHK,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_EMIT,
    ST_ERR
  } cu_state_t;

  typedef struct packed {
    logic fill_rd;
    logic fill_wr;
    logic load;
    logic tot_rd;
    logic tot_chk;
    logic probe_rd;
    logic probe_dec;
    logic take;
    logic emit;
    logic err_out;
  } cu_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic cfg_bad;
    logic rank_big;
    logic probe_more;
    logic out_free;
    logic last_elem;
  } cu_stat_t;

  // Row-major index of C(v,b) in the binomial table (row length MaxSet+1).
  function automatic logic [AddrW-1:0] tab_addr(input logic [NW-1:0] v,
                                                input logic [NW-1:0] b);
    logic [AddrW-1:0] vv;
    logic [AddrW-1:0] bb;
    vv = AddrW'(v);
    bb = AddrW'(b);
    return AddrW'(vv * AddrW'(TabRows)) + bb;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cu_ctrl.sv @@
// Controller state machine for combination unranking.
// Depends on cu_pkg; drives cu_dpath through cu_cmd_t and reads cu_stat_t.
`default_nettype none
module cu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cu_pkg::cu_stat_t stat,
  output cu_pkg::cu_cmd_t    cmd
);
  import cu_pkg::*;

  cu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL_RD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_nxt   = stat.fill_last ? ST_IDLE : ST_FILL_RD;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.cfg_bad ? ST_ERR : ST_TOT_RD;
        end
      end
      ST_TOT_RD: begin
        cmd.tot_rd = 1'b1;
        state_nxt  = ST_TOT_CHK;
      end
      ST_TOT_CHK: begin
        if (stat.rank_big) begin
          state_nxt = ST_ERR;
        end else begin
          cmd.tot_chk = 1'b1;
          state_nxt   = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (stat.probe_more) begin
          cmd.probe_dec = 1'b1;
          state_nxt     = ST_PROBE_RD;
        end else begin
          cmd.take  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last_elem ? ST_IDLE : ST_PROBE_RD;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.err_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_FILL_RD;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/cu_dpath.sv @@
// Datapath for combination unranking: config registers, binomial table memory,
// residual and candidate registers, output register. Depends on cu_pkg.
`default_nettype none
module cu_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cu_pkg::cu_cmd_t              cmd,
  output cu_pkg::cu_stat_t                  stat,
  input  wire logic [cu_pkg::RankW-1:0]     in_rank,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cu_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [cu_pkg::NW-1:0]        cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cu_pkg::ElemW-1:0]          out_element,
  output logic                              out_last,
  output logic                              out_error
);
  import cu_pkg::*;

  logic [NW-1:0]    n_r, k_r;
  logic [NW-1:0]    fv_r, fb_r;
  logic [ValW-1:0]  prev_r;
  logic [ValW-1:0]  rdata_r;
  logic [RankW-1:0] m_r;
  logic [ValW-1:0]  x_r;
  logic [NW-1:0]    v_r, b_r;
  logic             out_valid_r;
  logic [ElemW-1:0] out_element_r;
  logic             out_last_r, out_error_r;

  logic [ValW-1:0]  mem [0:TabDepth-1];
  logic [AddrW-1:0] raddr, waddr;
  logic [NW-1:0]    fv_up;
  logic [ValW-1:0]  fill_val;
  logic [NW-1:0]    elem_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= NW'(8);
      k_r <= NW'(4);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegSetSize:     n_r <= cfg_data;
        RegChooseCount: k_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table fill: row fv from row fv-1 by Pascal's rule, each entry read in ST_FILL_RD and written in ST_FILL_WR.
  assign fv_up    = (fv_r == '0) ? '0 : fv_r - NW'(1);
  assign fill_val = (fb_r == '0) ? ValW'(1) :
                    (fv_r == '0) ? '0 : prev_r + rdata_r;
  assign waddr    = tab_addr(fv_r, fb_r);

  always_comb begin
    if (cmd.fill_rd) begin
      raddr = tab_addr(fv_up, fb_r);
    end else if (cmd.tot_rd) begin
      raddr = tab_addr(n_r, k_r);
    end else begin
      raddr = tab_addr(v_r, b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      mem[waddr] <= fill_val;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      fb_r <= '0;
    end else if (cmd.fill_wr) begin
      if (fb_r == NW'(MaxSet)) begin
        fb_r <= '0;
        fv_r <= fv_r + NW'(1);
      end else begin
        fb_r <= fb_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      prev_r <= rdata_r;
    end
  end

  // Residual and candidate.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r <= in_rank;
      b_r <= k_r;
    end
    if (cmd.tot_chk) begin
      x_r <= rdata_r - ValW'(1) - ValW'(m_r);
      v_r <= n_r - NW'(1);
    end
    if (cmd.probe_dec) begin
      v_r <= v_r - NW'(1);
    end
    if (cmd.take) begin
      x_r <= x_r - rdata_r;
    end
    if (cmd.emit) begin
      v_r <= v_r - NW'(1);
      b_r <= b_r - NW'(1);
    end
  end

  assign elem_full = n_r - NW'(1) - v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.err_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_element_r <= elem_full[ElemW-1:0];
      out_last_r    <= (b_r == NW'(1));
      out_error_r   <= 1'b0;
    end else if (cmd.err_out) begin
      out_element_r <= '0;
      out_last_r    <= 1'b1;
      out_error_r   <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;
  assign out_error   = out_error_r;

  assign stat.fill_last  = (fv_r == NW'(MaxSet)) && (fb_r == NW'(MaxSet));
  assign stat.cfg_bad    = (n_r == '0) || (n_r > NW'(MaxSet)) || (k_r == '0) || (k_r > n_r);
  assign stat.rank_big   = ValW'(m_r) >= rdata_r;
  assign stat.probe_more = (v_r != '0) && (rdata_r > x_r);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last_elem  = (b_r == NW'(1));

endmodule
`default_nettype wire

@@ hw/rtl/combination_unrank.sv @@
// Top level of the combination unranking block: controller plus datapath.
// Depends on cu_pkg, cu_ctrl and cu_dpath.
//
//   channel | direction | ports                                  | handshake
//   --------+-----------+----------------------------------------+-----------------
//   in      | input     | in_rank                                | in_valid/in_ready
//   out     | output    | out_element, out_last, out_error       | out_valid/out_ready
//   cfg     | input     | cfg_index, cfg_data                    | cfg_valid/cfg_ready
//
// After reset the binomial table is built in memory, each entry read and then
// written; no request is taken until it is done.
// One request at a time: an accept, a fetch of C(n,k), a read and check per
// probe of the single table read port and an emit per output index, plus stalls.
// An error result follows a bad config at accept or a rank not below C(n,k).
// A stalled output holds the controller in place until the result is taken.
`default_nettype none
module combination_unrank (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cu_pkg::RankW-1:0]     in_rank,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cu_pkg::ElemW-1:0]          out_element,
  output logic                              out_last,
  output logic                              out_error,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cu_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [cu_pkg::NW-1:0]        cfg_data
);
  import cu_pkg::*;

  cu_cmd_t  cmd;
  cu_stat_t stat;

  cu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cu_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_rank     (in_rank),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_element (out_element),
    .out_last    (out_last),
    .out_error   (out_error)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cu_chk.sv @@
// Port-level checker for combination_unrank, bound to the top level.
// Depends on cu_pkg for port widths.
`default_nettype none
module cu_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [cu_pkg::RankW-1:0]     in_rank,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [cu_pkg::ElemW-1:0]     out_element,
  input wire logic                         out_last,
  input wire logic                         out_error,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [cu_pkg::CfgIdxW-1:0]   cfg_index,
  input wire logic [cu_pkg::NW-1:0]        cfg_data
);

  // An error result always closes its request.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error result without last");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element)
      && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

  // One request in flight: no accept right after an accept.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Reset drops the output.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind combination_unrank cu_chk u_cu_chk (.*);
`default_nettype wire
